### rtl/utx_pkg.sv
`default_nettype none

package utx_pkg;

   // Fragment size ceiling and header geometry
   localparam int unsigned MAX_FRAGMENT_BYTES = 1471;
   localparam int unsigned HDR_BYTES          = 28;
   localparam int unsigned UDP_HDR_BYTES      = 8;
   localparam int unsigned HDR_CNT_W          = $clog2(HDR_BYTES);
   localparam int unsigned FRAG_W             = 11;
   localparam int unsigned SUM_W              = 19;

   localparam logic [FRAG_W-1:0]    FRAG_CAP      = FRAG_W'(MAX_FRAGMENT_BYTES);
   localparam logic [HDR_CNT_W-1:0] HDR_LAST      = HDR_CNT_W'(HDR_BYTES - 1);
   localparam logic [15:0]          IP_TOT_EXTRA  = 16'(HDR_BYTES + 1);
   localparam logic [15:0]          UDP_LEN_EXTRA = 16'(UDP_HDR_BYTES + 1);

   // Fixed header bytes
   localparam logic [7:0]  IP_VER_IHL   = 8'h45;
   localparam logic [7:0]  IP_TTL       = 8'hFF;
   localparam logic [7:0]  IP_PROTO_UDP = 8'd17;
   // 0x4500 + 0xFF11: version/IHL/TOS word plus TTL/protocol word
   localparam logic [SUM_W-1:0] CKSUM_CONST = 19'h14411;

   // Command queue between front and back
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

   // Register port
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_IP      = 2'd0,
      CSR_SRC_PORT    = 2'd1,
      CSR_MAX_PAYLOAD = 2'd2
   } csr_index_type;

   localparam logic [31:0]       SRC_IP_RESET      = 32'h7F00_0001;
   localparam logic [15:0]       SRC_PORT_RESET    = 16'd30000;
   localparam logic [FRAG_W-1:0] MAX_PAYLOAD_RESET = 11'd1024;

   typedef struct packed {
      logic [31:0]       src_ip;
      logic [15:0]       src_port;
      logic [FRAG_W-1:0] max_payload;
   } cfg_type;

   // One classified payload word, as the back end replays it
   typedef struct packed {
      logic [7:0]        data_byte;
      logic              open;
      logic              close;
      logic              msg_end;
      logic [FRAG_W-1:0] frag_len;
      logic [15:0]       dgram_id;
      logic [31:0]       src_ip;
      logic [15:0]       src_port;
      logic [31:0]       dest_ip;
      logic [15:0]       dest_port;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_HEAD,
      BK_HDR,
      BK_PAY,
      BK_TRL
   } back_state_type;

endpackage

`default_nettype wire

### rtl/utx_req_if.sv
`default_nettype none

interface utx_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic [15:0] msg_len;
   logic [31:0] dest_ip;
   logic [15:0] dest_port;

   modport source (output valid, output data_byte, output msg_len, output dest_ip,
                   output dest_port, input ready);
   modport sink   (input valid, input data_byte, input msg_len, input dest_ip,
                   input dest_port, output ready);
endinterface

interface utx_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       datagram_end;
   logic       message_end;

   modport source (output valid, output out_byte, output datagram_end,
                   output message_end, input ready);
   modport sink   (input valid, input out_byte, input datagram_end,
                   input message_end, output ready);
endinterface

`default_nettype wire

### rtl/utx_front.sv
`default_nettype none

module utx_front
   import utx_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   utx_req_if.sink      req_ch,
   input  wire logic    full,
   output logic         push,
   output cmd_type      push_cmd
);

   logic [15:0]       msg_left_ff,  msg_left_in;
   logic [FRAG_W-1:0] frag_left_ff, frag_left_in;
   logic [15:0]       dgram_id_ff,  dgram_id_in;
   logic [31:0]       dest_ip_ff,   dest_ip_in;
   logic [15:0]       dest_port_ff, dest_port_in;

   logic              accept;
   logic              new_msg;
   logic              drop;
   logic              open;
   logic [15:0]       left;
   logic [FRAG_W-1:0] cap;
   logic [FRAG_W-1:0] frag;
   logic [FRAG_W-1:0] frag_cur;
   logic [FRAG_W-1:0] frag_next;
   logic [15:0]       left_next;
   logic [31:0]       cur_dest_ip;
   logic [15:0]       cur_dest_port;

   assign req_ch.ready = !full;
   assign accept       = req_ch.valid && req_ch.ready;

   // Classify the word: message start, fragment start, fragment and message end
   always_comb begin
      new_msg       = (msg_left_ff == 16'd0);
      drop          = new_msg && (req_ch.msg_len == 16'd0);
      left          = new_msg ? req_ch.msg_len   : msg_left_ff;
      cur_dest_ip   = new_msg ? req_ch.dest_ip   : dest_ip_ff;
      cur_dest_port = new_msg ? req_ch.dest_port : dest_port_ff;
      open          = new_msg || (frag_left_ff == '0);

      if (cfg.max_payload == '0) begin
         cap = FRAG_W'(1);
      end else if (cfg.max_payload > FRAG_CAP) begin
         cap = FRAG_CAP;
      end else begin
         cap = cfg.max_payload;
      end

      frag      = (left < 16'(cap)) ? left[FRAG_W-1:0] : cap;
      frag_cur  = open ? frag : frag_left_ff;
      frag_next = frag_cur - FRAG_W'(1);
      left_next = left - 16'd1;
   end

   // Build the command for the back end
   always_comb begin
      push               = accept && !drop;
      push_cmd.data_byte = req_ch.data_byte;
      push_cmd.open      = open;
      push_cmd.close     = (frag_next == '0);
      push_cmd.msg_end   = (left_next == 16'd0);
      push_cmd.frag_len  = frag_cur;
      push_cmd.dgram_id  = dgram_id_ff;
      push_cmd.src_ip    = cfg.src_ip;
      push_cmd.src_port  = cfg.src_port;
      push_cmd.dest_ip   = cur_dest_ip;
      push_cmd.dest_port = cur_dest_port;
   end

   // Advance message and fragment counters
   always_comb begin
      msg_left_in  = msg_left_ff;
      frag_left_in = frag_left_ff;
      dgram_id_in  = dgram_id_ff;
      dest_ip_in   = dest_ip_ff;
      dest_port_in = dest_port_ff;
      if (push) begin
         msg_left_in  = left_next;
         frag_left_in = frag_next;
         dest_ip_in   = cur_dest_ip;
         dest_port_in = cur_dest_port;
         if (open) begin
            dgram_id_in = dgram_id_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         msg_left_ff  <= '0;
         frag_left_ff <= '0;
         dgram_id_ff  <= 16'd1;
         dest_ip_ff   <= '0;
         dest_port_ff <= '0;
      end else begin
         msg_left_ff  <= msg_left_in;
         frag_left_ff <= frag_left_in;
         dgram_id_ff  <= dgram_id_in;
         dest_ip_ff   <= dest_ip_in;
         dest_port_ff <= dest_port_in;
      end
   end

endmodule

`default_nettype wire

### rtl/utx_fifo.sv
`default_nettype none

module utx_fifo
   import utx_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output logic         full,
   output logic         empty,
   output cmd_type      head
);

   cmd_type               mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_PTR_W:0]   count_ff,  count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full    = (count_ff == (FIFO_PTR_W+1)'(FIFO_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Move pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (FIFO_PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (FIFO_PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

### rtl/utx_back.sv
`default_nettype none

module utx_back
   import utx_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    empty,
   input  wire cmd_type head,
   output logic         pop,
   utx_rsp_if.source    rsp_ch
);

   back_state_type        state_ff, state_in;
   logic [HDR_CNT_W-1:0]  cnt_ff,   cnt_in;
   logic [SUM_W-1:0]      sum_ff,   sum_in;
   logic                  valid_ff;
   logic [7:0]            byte_ff,  byte_in;
   logic                  dend_ff,  dend_in;
   logic                  mend_ff,  mend_in;

   logic                  advance;
   logic                  busy;
   logic                  emit;
   logic                  hdr_active;
   logic [HDR_CNT_W-1:0]  hdr_idx;
   logic [7:0]            hdr_byte;
   logic [15:0]           tot_len;
   logic [15:0]           udp_len;
   logic [15:0]           cksum;

   assign advance = !valid_ff || rsp_ch.ready;
   assign busy    = (state_ff != BK_HEAD) || !empty;
   assign emit    = advance && busy;

   assign hdr_active = ((state_ff == BK_HEAD) && head.open) || (state_ff == BK_HDR);
   assign hdr_idx    = (state_ff == BK_HEAD) ? '0 : cnt_ff;
   assign tot_len    = IP_TOT_EXTRA  + 16'(head.frag_len);
   assign udp_len    = UDP_LEN_EXTRA + 16'(head.frag_len);
   assign cksum      = ~sum_ff[15:0];

   // Select the header byte at the current offset
   always_comb begin
      case (hdr_idx)
         5'd0:    hdr_byte = IP_VER_IHL;
         5'd2:    hdr_byte = tot_len[15:8];
         5'd3:    hdr_byte = tot_len[7:0];
         5'd4:    hdr_byte = head.dgram_id[15:8];
         5'd5:    hdr_byte = head.dgram_id[7:0];
         5'd8:    hdr_byte = IP_TTL;
         5'd9:    hdr_byte = IP_PROTO_UDP;
         5'd10:   hdr_byte = cksum[15:8];
         5'd11:   hdr_byte = cksum[7:0];
         5'd12:   hdr_byte = head.src_ip[31:24];
         5'd13:   hdr_byte = head.src_ip[23:16];
         5'd14:   hdr_byte = head.src_ip[15:8];
         5'd15:   hdr_byte = head.src_ip[7:0];
         5'd16:   hdr_byte = head.dest_ip[31:24];
         5'd17:   hdr_byte = head.dest_ip[23:16];
         5'd18:   hdr_byte = head.dest_ip[15:8];
         5'd19:   hdr_byte = head.dest_ip[7:0];
         5'd20:   hdr_byte = head.src_port[15:8];
         5'd21:   hdr_byte = head.src_port[7:0];
         5'd22:   hdr_byte = head.dest_port[15:8];
         5'd23:   hdr_byte = head.dest_port[7:0];
         5'd24:   hdr_byte = udp_len[15:8];
         5'd25:   hdr_byte = udp_len[7:0];
         default: hdr_byte = 8'h00;
      endcase
   end

   // Accumulate the header checksum while the first bytes go out, fold before offset 10
   always_comb begin
      sum_in = sum_ff;
      if (emit && hdr_active) begin
         case (hdr_idx)
            5'd0:    sum_in = CKSUM_CONST;
            5'd1:    sum_in = sum_ff + SUM_W'(tot_len);
            5'd2:    sum_in = sum_ff + SUM_W'(head.dgram_id);
            5'd3:    sum_in = sum_ff + SUM_W'(head.src_ip[31:16]);
            5'd4:    sum_in = sum_ff + SUM_W'(head.src_ip[15:0]);
            5'd5:    sum_in = sum_ff + SUM_W'(head.dest_ip[31:16]);
            5'd6:    sum_in = sum_ff + SUM_W'(head.dest_ip[15:0]);
            5'd7:    sum_in = SUM_W'(sum_ff[15:0]) + SUM_W'(sum_ff[SUM_W-1:16]);
            5'd8:    sum_in = SUM_W'(sum_ff[15:0]) + SUM_W'(sum_ff[16]);
            default: sum_in = sum_ff;
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_HEAD: begin
            if (emit) begin
               if (head.open) begin
                  state_in = BK_HDR;
               end else if (head.close) begin
                  state_in = BK_TRL;
               end
            end
         end
         BK_HDR: begin
            if (emit && (cnt_ff == HDR_LAST)) begin
               state_in = BK_PAY;
            end
         end
         BK_PAY: begin
            if (emit) begin
               state_in = head.close ? BK_TRL : BK_HEAD;
            end
         end
         BK_TRL: begin
            if (emit) begin
               state_in = BK_HEAD;
            end
         end
         default: state_in = BK_HEAD;
      endcase
   end

   // Outputs: the word to register and when to release the command
   always_comb begin
      byte_in = head.data_byte;
      dend_in = 1'b0;
      mend_in = 1'b0;
      pop     = 1'b0;
      unique case (state_ff)
         BK_HEAD: begin
            if (head.open) begin
               byte_in = hdr_byte;
            end else begin
               pop = emit && !head.close;
            end
         end
         BK_HDR: begin
            byte_in = hdr_byte;
         end
         BK_PAY: begin
            pop = emit && !head.close;
         end
         BK_TRL: begin
            byte_in = 8'h00;
            dend_in = 1'b1;
            mend_in = head.msg_end;
            pop     = emit;
         end
         default: begin
            byte_in = head.data_byte;
         end
      endcase
   end

   assign cnt_in = (emit && hdr_active) ? hdr_idx + HDR_CNT_W'(1) : cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_HEAD;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (advance) begin
            valid_ff <= emit;
         end
      end
   end

   // Hold the output word while stalled
   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      if (advance) begin
         byte_ff <= byte_in;
         dend_ff <= dend_in;
         mend_ff <= mend_in;
      end
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.out_byte     = byte_ff;
   assign rsp_ch.datagram_end = dend_ff;
   assign rsp_ch.message_end  = mend_ff;

endmodule

`default_nettype wire

### rtl/udp_ipv4_tx_framer.sv
// Channel | Dir | Word                                        | Handshake
// req_ch  | in  | data_byte, msg_len, dest_ip, dest_port      | valid/ready
// rsp_ch  | out | out_byte, datagram_end, message_end         | valid/ready
// csr_*   | in  | csr_index selects register, csr_wdata value | csr_we, no wait
//
// Input takes one word a cycle while the 4-entry command queue has room.
// Output sends one byte a cycle while the receiver is ready; a fragment of n
// bytes leaves as 28 header bytes, n payload bytes and one trailing zero, so
// the output byte rate sets sustained input rate. Reset (synchronous) empties
// the queue, clears counters, sets the id to 1 and the registers to their
// defaults. Either side may stall without losing words.
`default_nettype none

module udp_ipv4_tx_framer
   import utx_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   utx_req_if.sink                    req_ch,
   utx_rsp_if.source                  rsp_ch,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    push;
   cmd_type push_cmd;
   logic    pop;
   logic    full;
   logic    empty;
   cmd_type head;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SRC_IP:      cfg_in.src_ip      = csr_wdata;
            CSR_SRC_PORT:    cfg_in.src_port    = csr_wdata[15:0];
            CSR_MAX_PAYLOAD: cfg_in.max_payload = csr_wdata[FRAG_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_ip      <= SRC_IP_RESET;
         cfg_ff.src_port    <= SRC_PORT_RESET;
         cfg_ff.max_payload <= MAX_PAYLOAD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   utx_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_ch   (req_ch),
      .full     (full),
      .push     (push),
      .push_cmd (push_cmd)
   );

   utx_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (full),
      .empty    (empty),
      .head     (head)
   );

   utx_back u_back (
      .clock  (clock),
      .reset  (reset),
      .empty  (empty),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

`default_nettype wire

### rtl/utx_checker.sv
`default_nettype none

module utx_checker
   import utx_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_datagram_end,
   input wire logic       rsp_message_end
);

   logic at_start_ff;

   // Track whether the next byte opens a datagram
   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
         at_start_ff <= rsp_datagram_end;
      end
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_datagram_end) && $stable(rsp_message_end))
      else $error("stalled output word changed");

   a_msg_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_message_end |-> rsp_datagram_end)
      else $error("message end without datagram end");

   a_trailer_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_datagram_end |-> rsp_out_byte == 8'h00)
      else $error("datagram trailer byte not zero");

   a_header_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && at_start_ff |-> rsp_out_byte == IP_VER_IHL && !rsp_datagram_end)
      else $error("datagram does not open with version and header length");

endmodule

bind udp_ipv4_tx_framer utx_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_out_byte     (rsp_ch.out_byte),
   .rsp_datagram_end (rsp_ch.datagram_end),
   .rsp_message_end  (rsp_ch.message_end)
);

`default_nettype wire
